// ----- src/wspc_pkg.sv -----
// ----------------------------------------------------------------------------
// Spindle pace controller package
// Shared types and constants for the winding spindle pace controller.
// ----------------------------------------------------------------------------
package wspc_pkg;

   localparam int unsigned PULSES_PER_TURN = 15;
   localparam int unsigned PULSES_PER_STEP = 3;

   localparam int unsigned TURN_PHASE_W = $clog2(PULSES_PER_TURN + 1);
   localparam int unsigned STEP_PHASE_W = $clog2(PULSES_PER_STEP + 1);

   localparam logic [TURN_PHASE_W-1:0] TURN_PHASE_LAST = TURN_PHASE_W'(PULSES_PER_TURN - 1);
   localparam logic [STEP_PHASE_W-1:0] STEP_PHASE_LAST = STEP_PHASE_W'(PULSES_PER_STEP - 1);

   localparam logic [31:0] PERIOD_RESET = 32'd400;
   localparam logic [7:0]  DUTY_RESET   = 8'd255;
   localparam logic [7:0]  DUTY_MAX     = 8'd255;
   localparam logic [7:0]  DUTY_MIN     = 8'd0;

   // event codes
   localparam logic [1:0] MODE_START = 2'd0;
   localparam logic [1:0] MODE_HALL  = 2'd1;
   localparam logic [1:0] MODE_STOP  = 2'd2;

   typedef struct packed {
      logic [1:0]  mode;
      logic [15:0] rotation_count;
      logic [31:0] time_us;
   } req_type;

   typedef struct packed {
      logic [7:0]  motor_duty;
      logic        running;
      logic        guide_step;
      logic        run_done;
      logic [15:0] turns_done;
   } rsp_type;

   // pulse count is kept as whole turns plus pulses into the current turn
   typedef struct packed {
      logic                    active;
      logic [15:0]             turns;
      logic [TURN_PHASE_W-1:0] turn_phase;
      logic [STEP_PHASE_W-1:0] step_phase;
      logic [15:0]             rot_target;
      logic [31:0]             last_edge_time;
      logic                    edge_seen;
      logic [7:0]              duty_level;
   } state_type;

   localparam state_type STATE_RESET = '{duty_level: DUTY_RESET, default: '0};

endpackage

// ----- src/wspc_update.sv -----
// ----------------------------------------------------------------------------
// Spindle pace update
// Next-state and response logic for one event transfer.
// ----------------------------------------------------------------------------
module wspc_update (
   input  wspc_pkg::state_type cur_state,
   input  wspc_pkg::req_type   req,
   input  logic [31:0]         pulse_period_us,
   output wspc_pkg::state_type nxt_state,
   output wspc_pkg::rsp_type   rsp
);
   import wspc_pkg::*;

   state_type   nxt;
   logic        step;
   logic        done;
   logic [31:0] pace;

   assign pace = req.time_us - cur_state.last_edge_time;

   always_comb begin
      nxt  = cur_state;
      step = 1'b0;
      done = 1'b0;
      case (req.mode)
         MODE_START: begin
            if (!cur_state.active) begin
               nxt.turns          = '0;
               nxt.turn_phase     = '0;
               nxt.step_phase     = '0;
               nxt.last_edge_time = '0;
               nxt.edge_seen      = 1'b0;
               nxt.rot_target     = req.rotation_count;
               nxt.active         = 1'b1;
            end
         end
         MODE_HALL: begin
            if (cur_state.active) begin
               if (cur_state.turn_phase == TURN_PHASE_LAST) begin
                  nxt.turn_phase = '0;
                  nxt.turns      = cur_state.turns + 16'd1;
               end else begin
                  nxt.turn_phase = cur_state.turn_phase + TURN_PHASE_W'(1);
               end
               if (cur_state.step_phase == STEP_PHASE_LAST) begin
                  nxt.step_phase = '0;
                  step           = 1'b1;
               end else begin
                  nxt.step_phase = cur_state.step_phase + STEP_PHASE_W'(1);
               end
               // turns*PPT+phase >= rot*PPT  <=>  turns >= rot
               if (nxt.turns >= cur_state.rot_target) begin
                  nxt.active = 1'b0;
                  done       = 1'b1;
               end else begin
                  if (cur_state.edge_seen) begin
                     if (pace > pulse_period_us && cur_state.duty_level != DUTY_MAX) begin
                        nxt.duty_level = cur_state.duty_level + 8'd1;
                     end else if (pace < pulse_period_us &&
                                  cur_state.duty_level != DUTY_MIN) begin
                        nxt.duty_level = cur_state.duty_level - 8'd1;
                     end
                  end
                  nxt.last_edge_time = req.time_us;
                  nxt.edge_seen      = 1'b1;
               end
            end
         end
         MODE_STOP: begin
            nxt.active = 1'b0;
         end
         default: begin
         end
      endcase
   end

   assign nxt_state      = nxt;
   assign rsp.motor_duty = nxt.active ? nxt.duty_level : 8'd0;
   assign rsp.running    = nxt.active;
   assign rsp.guide_step = step;
   assign rsp.run_done   = done;
   assign rsp.turns_done = nxt.turns;

endmodule

// ----- src/winding_spindle_pace_controller_core.sv -----
// ----------------------------------------------------------------------------
// Winding spindle pace controller
// Latency: a response is valid in the cycle after its event transfer.
// Throughput: one event per cycle while the response side does not stall; state
// and the response register update together, so back-to-back events see each other's state.
// Reset (synchronous): idle, pulse count clear, duty 255, period 400 us.
// ----------------------------------------------------------------------------
module winding_spindle_pace_controller_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  wspc_pkg::req_type  req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output wspc_pkg::rsp_type  rsp_data,
   input  logic               csr_write_en,
   input  logic [31:0]        csr_write_data
);
   import wspc_pkg::*;

   state_type   state_ff;
   state_type   state_in;
   rsp_type     rsp_data_ff;
   rsp_type     rsp_data_in;
   logic        rsp_valid_ff;
   logic        rsp_valid_in;
   logic [31:0] period_ff;
   logic [31:0] period_in;
   logic        req_xfer;

   // output register frees up when its contents are taken
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_xfer  = req_valid && req_ready;

   wspc_update u_update (
      .cur_state       (state_ff),
      .req             (req_data),
      .pulse_period_us (period_ff),
      .nxt_state       (state_in),
      .rsp             (rsp_data_in)
   );

   assign rsp_valid_in = req_xfer || (rsp_valid_ff && !rsp_ready);
   assign period_in    = csr_write_en ? csr_write_data : period_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff                <= STATE_RESET;
         rsp_valid_ff            <= 1'b0;
         period_ff               <= PERIOD_RESET;
      end else begin
         if (req_xfer) begin
            state_ff <= state_in;
         end
         rsp_valid_ff <= rsp_valid_in;
         period_ff    <= period_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ----- src/wspc_checker.sv -----
// ----------------------------------------------------------------------------
// Spindle pace controller checker
// Port-level assertions, bound to the core.
// ----------------------------------------------------------------------------
module wspc_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input wspc_pkg::rsp_type rsp_data
);
   import wspc_pkg::*;

   // a held response keeps its contents
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   // every event transfer yields a response in the next cycle
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("no response after event transfer");

   // a stalled response blocks new events
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("event taken while response stalled");

   a_idle_duty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.running |-> rsp_data.motor_duty == 8'd0)
      else $error("duty driven while idle");

   a_done_stops: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.run_done |-> !rsp_data.running)
      else $error("run still active after done");

endmodule

bind winding_spindle_pace_controller_core wspc_checker u_wspc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

// ----- test/winding_spindle_pace_controller_core_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Spindle pace controller testbench
// Sends start, hall and stop events to the core with random gaps while the
// response side stalls at random. Every response is compared field by field
// against a cycle-free predictor that tracks run state, pulse count, guide
// stepping and duty pacing. The pace period is rewritten between phases,
// including zero and all-ones, so the duty saturates at both rails.
// ----------------------------------------------------------------------------
module winding_spindle_pace_controller_core_tb;
   import wspc_pkg::*;

   localparam logic [1:0]  MODE_NONE    = 2'd3;   // unused event code
   localparam int unsigned QUIET_LIMIT  = 2000;
   localparam int unsigned DRAIN_CYCLES = 4;

   typedef struct packed {
      logic        running;
      logic [23:0] pulses;
      logic [23:0] target;
      logic [31:0] last_edge;
      logic        edge_seen;
      logic [7:0]  duty;
      logic [7:0]  step_phase;
   } spindle_state_type;

   logic    clock          = 1'b0;
   logic    reset          = 1'b1;
   logic    req_valid      = 1'b0;
   logic    req_ready;
   req_type req_data       = '0;
   logic    rsp_valid;
   logic    rsp_ready      = 1'b0;
   rsp_type rsp_data;
   logic    csr_write_en   = 1'b0;
   logic [31:0] csr_write_data = '0;

   spindle_state_type spin;
   logic [31:0]    period_model;
   rsp_type        expected_status[$];

   bit          req_steady;
   bit          rsp_steady;
   int unsigned rsp_hold;
   int unsigned events_sent;
   int unsigned results_seen;
   int unsigned runs_finished;
   int unsigned guide_steps;
   int unsigned failures;

   winding_spindle_pace_controller_core dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic int unsigned pick_wait(input bit steady);
      return steady ? 0 : $urandom_range(0, 12);
   endfunction

   // predicted status after one event; updates the predictor state
   function automatic rsp_type advance_spindle(input req_type ev);
      rsp_type     r;
      logic [31:0] pace;
      r = '0;
      case (ev.mode)
         MODE_START: begin
            if (!spin.running) begin
               spin.pulses     = '0;
               spin.step_phase = '0;
               spin.last_edge  = '0;
               spin.edge_seen  = 1'b0;
               spin.target     = 24'(ev.rotation_count) * 24'(PULSES_PER_TURN);
               spin.running    = 1'b1;
            end
         end
         MODE_HALL: begin
            if (spin.running) begin
               spin.pulses++;
               spin.step_phase++;
               if (spin.step_phase >= 8'(PULSES_PER_STEP)) begin
                  spin.step_phase = '0;
                  r.guide_step    = 1'b1;
                  guide_steps++;
               end
               if (spin.pulses >= spin.target) begin
                  spin.running = 1'b0;
                  r.run_done   = 1'b1;
                  runs_finished++;
               end else begin
                  // first edge of a run only records the time
                  if (spin.edge_seen) begin
                     pace = ev.time_us - spin.last_edge;
                     if (pace > period_model && spin.duty != DUTY_MAX)
                        spin.duty++;
                     else if (pace < period_model && spin.duty != DUTY_MIN)
                        spin.duty--;
                  end
                  spin.last_edge = ev.time_us;
                  spin.edge_seen = 1'b1;
               end
            end
         end
         MODE_STOP: spin.running = 1'b0;
         default: ;
      endcase
      r.motor_duty = spin.running ? spin.duty : DUTY_MIN;
      r.running    = spin.running;
      r.turns_done = 16'(spin.pulses / 24'(PULSES_PER_TURN));
      return r;
   endfunction

   function automatic void check_field(input string name, input longint unsigned want,
                                       input longint unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         failures++;
      end
   endfunction

   // response checking and prediction, all on sampled values at the rising edge
   always @(posedge clock) begin : status_monitor
      rsp_type want;
      if (reset) begin
         spin         = '0;
         spin.duty    = DUTY_RESET;
         period_model = PERIOD_RESET;
      end else begin
         if (rsp_valid && rsp_ready) begin
            rsp_hold = pick_wait(rsp_steady);
            results_seen++;
            if (expected_status.size() == 0) begin
               $error("response transfer with nothing outstanding");
               failures++;
            end else begin
               want = expected_status.pop_front();
               check_field("motor_duty", want.motor_duty, rsp_data.motor_duty);
               check_field("running",    want.running,    rsp_data.running);
               check_field("guide_step", want.guide_step, rsp_data.guide_step);
               check_field("run_done",   want.run_done,   rsp_data.run_done);
               check_field("turns_done", want.turns_done, rsp_data.turns_done);
            end
         end
         if (csr_write_en)
            period_model = csr_write_data;
         if (req_valid && req_ready)
            expected_status.push_back(advance_spindle(req_data));
      end
   end

   always @(negedge clock) begin
      if (rsp_hold > 0) begin
         rsp_ready <= 1'b0;
         rsp_hold--;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   initial begin : watchdog
      int unsigned quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset || csr_write_en || (req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("[FAIL] regression broken");
      $finish;
   end

   task automatic send_event(input logic [1:0] mode, input logic [15:0] rot,
                             input logic [31:0] stamp);
      int unsigned gap;
      gap = pick_wait(req_steady);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid               <= 1'b1;
      req_data.mode           <= mode;
      req_data.rotation_count <= rot;
      req_data.time_us        <= stamp;
      do @(posedge clock); while (req_ready !== 1'b1);
      events_sent++;
   endtask

   task automatic send_noise();
      send_event(2'($urandom_range(0, 3)), 16'($urandom), $urandom);
   endtask

   // drop valid and wait until every response is back
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_status.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_period(input logic [31:0] value);
      @(negedge clock);
      csr_write_en   <= 1'b1;
      csr_write_data <= value;
      @(negedge clock);
      csr_write_en   <= 1'b0;
   endtask

   // one start, a train of hall edges paced around the period, maybe a stop
   task automatic wind_run(input logic [31:0] period);
      int unsigned rot;
      int unsigned halls;
      int unsigned target;
      logic [31:0] now;
      logic [31:0] delta;
      req_steady = ($urandom_range(0, 4) == 0);
      rsp_steady = ($urandom_range(0, 4) == 0);
      rot    = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 6);
      target = rot * PULSES_PER_TURN;
      halls  = (target == 0) ? 1 : target;
      if (halls > 90 || $urandom_range(0, 3) == 0)
         halls = $urandom_range(1, (halls > 90) ? 90 : halls);
      now = $urandom;
      send_event(MODE_START, 16'(rot), $urandom);
      for (int unsigned i = 0; i < halls; i++) begin
         case ($urandom_range(0, 7))
            0:       delta = period;
            1:       delta = $urandom;
            default: delta = period + 32'($urandom_range(0, 6)) - 32'd3;
         endcase
         now += delta;
         send_event(MODE_HALL, 16'($urandom), now);
         if ($urandom_range(0, 11) == 0)
            send_noise();
      end
      if (halls < target || $urandom_range(0, 3) == 0)
         send_event(MODE_STOP, 16'($urandom), $urandom);
   endtask

   task automatic wind_phase(input logic [31:0] period, input int unsigned budget);
      int unsigned stop_at;
      // sender holds off here until all responses are in
      settle();
      write_period(period);
      stop_at = events_sent + budget;
      while (events_sent < stop_at) begin
         if ($urandom_range(0, 5) == 0)
            send_noise();
         else
            wind_run(period);
      end
   endtask

   task automatic test_idle_events();
      send_event(MODE_HALL, 16'hFFFF, 32'hFFFF_FFFF);
      send_event(MODE_STOP, 16'h0000, 32'h0000_0000);
      send_event(MODE_NONE, 16'hA5A5, 32'h5A5A_5A5A);
   endtask

   task automatic test_zero_rotations();
      send_event(MODE_START, 16'd0, 32'd0);
      send_event(MODE_HALL,  16'd0, 32'd1234);   // ends the run at once
      send_event(MODE_HALL,  16'd0, 32'd5678);   // idle again
   endtask

   task automatic test_pacing_edges();
      send_event(MODE_START, 16'd1, 32'd0);
      send_event(MODE_HALL,  16'd0, 32'h0000_0000);   // first edge, time only
      send_event(MODE_HALL,  16'd0, 32'hFFFF_FFFF);   // slow, duty already at ceiling
      send_event(MODE_HALL,  16'd0, 32'h0000_0100);   // wraps to a short pace
      send_event(MODE_HALL,  16'd0, 32'h0000_0290);   // pace equals period
      send_event(MODE_HALL,  16'd0, 32'h0000_0291);
      send_event(MODE_HALL,  16'd0, 32'h0000_0679);
      send_event(MODE_START, 16'd9, 32'd0);           // ignored while running
      send_event(MODE_NONE,  16'd0, 32'd0);
      send_event(MODE_STOP,  16'd0, 32'd0);
   endtask

   task automatic test_max_rotations();
      send_event(MODE_START, 16'hFFFF, 32'hFFFF_FFFF);
      send_event(MODE_HALL,  16'h0000, 32'h8000_0000);
      send_event(MODE_HALL,  16'h0000, 32'h8000_0190);
      send_event(MODE_STOP,  16'hFFFF, 32'd0);
   endtask

   task automatic test_nominal_pace();
      wind_phase(32'($urandom_range(100, 1000)), 110);
   endtask

   // all-ones period: nearly every pace is short, duty walks down to zero
   task automatic test_duty_floor();
      wind_phase(32'hFFFF_FFFF, 170);
   endtask

   // zero period: nearly every pace is long, duty walks back up to the ceiling
   task automatic test_duty_ceiling();
      wind_phase(32'h0000_0000, 170);
   endtask

   task automatic test_random_pace();
      wind_phase($urandom, 110);
      wind_phase(32'($urandom_range(1, 2000)), 120);
   endtask

   initial begin : regression
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_idle_events();
      test_zero_rotations();
      test_pacing_edges();
      test_max_rotations();
      test_nominal_pace();
      test_duty_floor();
      test_duty_ceiling();
      test_random_pace();

      settle();
      $display("Covered %0d events and %0d responses over six pace settings,",
               events_sent, results_seen);
      $display("with %0d completed runs and %0d guide steps.", runs_finished, guide_steps);
      if (failures == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

// ----- files.f -----
src/wspc_pkg.sv
src/wspc_update.sv
src/winding_spindle_pace_controller_core.sv
src/wspc_checker.sv
test/winding_spindle_pace_controller_core_tb.sv
